// File: hw/rtl/egd_pkg.sv
// egd_pkg: shared constants, types and register codes for the 3x3 edge gradient core
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package egd_pkg;

  // pixel and result payload widths
  localparam int PIX_W = 8;
  localparam int MAG_W = 8;

  // line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // configuration register widths and reset values
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 16;
  localparam int DATA_W   = 16;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);

  // window row/column sums: three pixels
  localparam int SUM_W = PIX_W + 2;

  // register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  // line store access for one pixel: read at accept, write when it leaves the read stage
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } lb_req_t;

endpackage

// File: hw/rtl/egd_if.sv
// egd_if: valid/ready stream interfaces for the pixel and result channels
// depends on egd_pkg for payload widths
`timescale 1ns / 1ps

interface egd_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [egd_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface egd_result_if;
  logic                      valid;
  logic                      ready;
  logic [egd_pkg::MAG_W-1:0] magnitude;
  logic                      last;

  modport source (output valid, output magnitude, output last, input ready);
  modport sink   (input valid, input magnitude, input last, output ready);
endinterface

// File: hw/rtl/egd_line_buf.sv
// egd_line_buf: the two previous-row stores with registered read
// depends on egd_pkg; store a holds the previous row, store b the row before it
`timescale 1ns / 1ps

module egd_line_buf (
  input  logic                      clk,
  input  egd_pkg::lb_req_t          req,
  input  logic [egd_pkg::PIX_W-1:0] pixel,
  output logic [egd_pkg::PIX_W-1:0] top,
  output logic [egd_pkg::PIX_W-1:0] mid
);
  import egd_pkg::*;

  logic [PIX_W-1:0] line_store_a [MAX_WIDTH];
  logic [PIX_W-1:0] line_store_b [MAX_WIDTH];

  // registered read, held until the next request is read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mid <= line_store_a[req.rd_addr];
      top <= line_store_b[req.rd_addr];
    end
  end

  // row shift: previous row moves down, new pixel enters store a
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      line_store_b[req.wr_addr] <= mid;
      line_store_a[req.wr_addr] <= pixel;
    end
  end

endmodule

// File: hw/rtl/egd_gradient.sv
// egd_gradient: 3x3 window shift register and row/column difference magnitude
// depends on egd_pkg; magnitude is computed from the window as it will be after the shift
`timescale 1ns / 1ps

module egd_gradient (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic [egd_pkg::PIX_W-1:0] top,
  input  logic [egd_pkg::PIX_W-1:0] mid,
  input  logic [egd_pkg::PIX_W-1:0] pixel,
  output logic [egd_pkg::MAG_W-1:0] magnitude
);
  import egd_pkg::*;

  logic [PIX_W-1:0] window      [9];
  logic [PIX_W-1:0] window_next [9];
  logic [SUM_W-1:0] top_sum, bot_sum, left_sum, right_sum;
  logic [SUM_W-1:0] row_diff, col_diff;
  logic [SUM_W:0]   total;

  // shift left by one column, new column enters on the right
  always_comb begin
    window_next[0] = window[1];
    window_next[1] = window[2];
    window_next[2] = top;
    window_next[3] = window[4];
    window_next[4] = window[5];
    window_next[5] = mid;
    window_next[6] = window[7];
    window_next[7] = window[8];
    window_next[8] = pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) window[i] <= '0;
    end else if (shift) begin
      for (int i = 0; i < 9; i++) window[i] <= window_next[i];
    end
  end

  // unit-weight row and column sums
  always_comb begin
    top_sum   = SUM_W'(window_next[0]) + SUM_W'(window_next[1]) + SUM_W'(window_next[2]);
    bot_sum   = SUM_W'(window_next[6]) + SUM_W'(window_next[7]) + SUM_W'(window_next[8]);
    left_sum  = SUM_W'(window_next[0]) + SUM_W'(window_next[3]) + SUM_W'(window_next[6]);
    right_sum = SUM_W'(window_next[2]) + SUM_W'(window_next[5]) + SUM_W'(window_next[8]);
    row_diff  = (top_sum > bot_sum) ? top_sum - bot_sum : bot_sum - top_sum;
    col_diff  = (left_sum > right_sum) ? left_sum - right_sum : right_sum - left_sum;
    total     = {1'b0, row_diff} + {1'b0, col_diff};
    magnitude = total[MAG_W-1:0];
  end

endmodule

// File: hw/rtl/edge_gradient_3x3_core.sv
// edge_gradient_3x3_core: streaming 3x3 edge magnitude over a raster pixel stream
// depends on egd_pkg, egd_if, egd_line_buf and egd_gradient
`timescale 1ns / 1ps

// Accepts one 8-bit gray pixel per clock, unless the result channel stalls, in
// raster order and returns, for every interior pixel, |top row sum - bottom row
// sum| + |left column sum - right column sum| of its 3x3 neighborhood modulo 256,
// with last set on the final interior pixel of the frame; border pixels give no
// result. Throughput is one pixel per clock while result_out is ready. The pixel
// that completes a window passes the registered read of the line memories, then
// the window and output register. image_width (index 0) is clamped to 3..1024 and
// image_height (index 1) to at least 3; any register write restarts the frame.
// Line memories need no clearing: entries are always written before they reach a
// result.
module edge_gradient_3x3_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [0:0]                   wr_index,
  input  logic [egd_pkg::DATA_W-1:0]   wr_data,
  egd_pixel_if.sink                    pixel_in,
  egd_result_if.source                 result_out
);
  import egd_pkg::*;

  // configuration and frame position
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [ADDR_W-1:0]   column_count, column_count_next;
  logic [HEIGHT_W-1:0] row_count, row_count_next;

  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [ADDR_W-1:0]   col_cur;
  logic [HEIGHT_W-1:0] row_cur;
  logic                col_wrap, row_wrap, emit_cur, last_cur;

  // read stage
  logic                s1_valid, s1_emit, s1_last;
  logic [ADDR_W-1:0]   s1_col;
  logic [PIX_W-1:0]    s1_pixel;
  logic                in_accept, s1_advance;

  lb_req_t             lb_req;
  logic [PIX_W-1:0]    top, mid;
  logic [MAG_W-1:0]    magnitude;

  // output register
  logic                out_valid;
  logic [MAG_W-1:0]    out_magnitude;
  logic                out_last;

  // effective geometry
  always_comb begin
    if (image_width < WIDTH_MIN)      width_eff = WIDTH_MIN;
    else if (image_width > WIDTH_MAX) width_eff = WIDTH_MAX;
    else                              width_eff = image_width;
    height_eff = (image_height < HEIGHT_MIN) ? HEIGHT_MIN : image_height;
  end

  // position of the incoming pixel and the next one
  always_comb begin
    col_cur  = ({1'b0, column_count} >= width_eff) ? '0 : column_count;
    row_cur  = (row_count >= height_eff) ? '0 : row_count;
    col_wrap = ({1'b0, col_cur} + WIDTH_W'(1)) >= width_eff;
    row_wrap = ({1'b0, row_cur} + (HEIGHT_W+1)'(1)) >= {1'b0, height_eff};
    emit_cur = (row_cur >= HEIGHT_W'(2)) && (col_cur >= ADDR_W'(2));
    last_cur = (row_cur == height_eff - HEIGHT_W'(1)) &&
               ({1'b0, col_cur} == width_eff - WIDTH_W'(1));
    if (col_wrap) begin
      column_count_next = '0;
      row_count_next    = row_wrap ? '0 : row_cur + HEIGHT_W'(1);
    end else begin
      column_count_next = col_cur + ADDR_W'(1);
      row_count_next    = row_cur;
    end
  end

  // handshake: read stage moves when the output register is free or draining
  assign s1_advance     = s1_valid && (!out_valid || result_out.ready);
  assign pixel_in.ready = !s1_valid || s1_advance;
  assign in_accept      = pixel_in.valid && pixel_in.ready;

  // register writes, frame restart on any write
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_IMAGE_WIDTH:  image_width  <= wr_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= wr_data[HEIGHT_W-1:0];
        default: ;
      endcase
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_emit  <= emit_cur;
      s1_last  <= last_cur;
      s1_col   <= col_cur;
      s1_pixel <= pixel_in.pixel;
    end
  end

  // line stores: read on accept, write back when the window shifts
  always_comb begin
    lb_req.rd_en   = in_accept;
    lb_req.rd_addr = col_cur;
    lb_req.wr_en   = s1_advance;
    lb_req.wr_addr = s1_col;
  end

  egd_line_buf u_line_buf (
    .clk   (clk),
    .req   (lb_req),
    .pixel (s1_pixel),
    .top   (top),
    .mid   (mid)
  );

  egd_gradient u_gradient (
    .clk       (clk),
    .rst       (rst),
    .shift     (s1_advance),
    .top       (top),
    .mid       (mid),
    .pixel     (s1_pixel),
    .magnitude (magnitude)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_emit;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_emit) begin
      out_magnitude <= magnitude;
      out_last      <= s1_last;
    end
  end

  assign result_out.valid     = out_valid;
  assign result_out.magnitude = out_magnitude;
  assign result_out.last      = out_last;

  // an accepted request always sits in the read stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted pixel did not reach the read stage");

  // only interior columns produce a result
  a_emit_interior: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_emit) |-> (s1_col >= ADDR_W'(2)))
    else $error("result flagged for a border column");

  // a register write restarts the frame
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (column_count == '0 && row_count == '0))
    else $error("frame position not cleared after register write");

  // line store write never targets the address read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (lb_req.rd_en && lb_req.wr_en) |-> (lb_req.rd_addr != lb_req.wr_addr))
    else $error("line store read and write collide");

endmodule
